// ===== rtl/core/pmsg1_pkg.sv =====
// Shared types and constants for the Phong microfacet G1 shadowing pipeline.
`timescale 1ns / 1ps

package pmsg1_pkg;

    // Input vectors are signed Q1.14, the result is unsigned Q1.15.
    localparam int VEC_FRAC_BITS = 14;
    localparam int OUT_FRAC_BITS = 15;

    // Quotient widths of the two dividers and root width of the square root.
    localparam int DIV1_BITS = 38;
    localparam int SQRT_BITS = 17;
    localparam int DIV2_BITS = 16;

    // Total register stages from input acceptance to the output register.
    localparam int LATENCY = 5 + DIV1_BITS + 2 + SQRT_BITS + 3 + DIV2_BITS + 1;

    // Rational coefficients, 16 fraction bits, rounded to nearest.
    localparam logic [17:0] K_A1 = 18'd231670;
    localparam logic [17:0] K_A2 = 18'd142934;
    localparam logic [17:0] K_B1 = 18'd181338;
    localparam logic [17:0] K_B2 = 18'd168886;

    // Smallest a^2 (32 fraction bits) with 25 * a^2 >= 64 << 32, i.e. a >= 1.6.
    localparam logic [63:0] A2_SAT = 64'd10995116278;

    localparam logic [15:0] SHADOW_ONE = 16'(1 << OUT_FRAC_BITS);

    typedef struct packed {
        logic back;
        logic sat;
    } t_tag;

    typedef struct packed {
        logic [30:0] den;
        logic [30:0] rem;
        logic [37:0] quo;
        logic [5:0]  low;
        t_tag        tag;
    } t_div1;

    typedef struct packed {
        logic [33:0] x;
        logic [18:0] rem;
        logic [16:0] root;
        t_tag        tag;
    } t_sqrt;

    typedef struct packed {
        logic [20:0] den;
        logic [20:0] rem;
        logic [15:0] quo;
        logic        low;
        t_tag        tag;
    } t_div2;

endpackage

// ===== rtl/core/phong_microfacet_shadowing_g1.sv =====
// Top level: fully pipelined Smith G1 shadowing term for a Phong microfacet model.
`timescale 1ns / 1ps

// Usage
//   Slave stream (i_s_*): one item per accepted beat, three unit vectors in Q1.14.
//   Master stream (o_m_*): one result item per input item, in order. tdata holds
//   the shadowing term in unsigned Q1.15, tuser the backfacing flag.
//   Config: pulse i_cfg_we with the Phong exponent (Q16.8) on i_cfg_wdata; write
//   it only while the pipeline is empty.
// Depth and throughput
//   82 register stages, one item per cycle sustained while the output is not
//   stalled. The depth is set by the two restoring dividers (38 and 16 quotient
//   bits, one bit a stage) and the 17-stage digit-by-digit root.
// Reset
//   Clears every valid bit and loads the exponent with 1.0; payload is not reset.
// Stall
//   While a result waits in the output register and i_m_tready is low, the whole
//   pipeline holds and o_s_tready drops; nothing is lost or repeated. A bubble in
//   the output register lets the pipe advance again.
module phong_microfacet_shadowing_g1
    import pmsg1_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [23:0]  i_cfg_wdata,      // phong_exponent
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // normal_x, normal_y, normal_z, view_x, view_y, view_z,
    // facet_x, facet_y, facet_z (16 bits each, lowest first)
    input  logic [143:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [15:0]  o_m_tdata,        // shadowing
    output logic         o_m_tuser         // backfacing
);

    logic [23:0]        r_phong_exponent;
    logic [LATENCY-1:0] r_vld;
    logic               w_en;
    logic               w_in_fire;

    // Advance the whole pipe unless a finished item is stuck at the output.
    assign w_en       = i_m_tready || !r_vld[LATENCY-1];
    assign o_s_tready = w_en;
    assign w_in_fire  = i_s_tvalid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phong_exponent <= 24'd256;
        end else if (i_cfg_we) begin
            r_phong_exponent <= i_cfg_wdata;
        end
    end

    // Valid bits ride along with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LATENCY-2:0], w_in_fire};
        end
    end

    // ---------------- Stage 1: component products ----------------
    logic signed [15:0] w_nx, w_ny, w_nz, w_vx, w_vy, w_vz, w_fx, w_fy, w_fz;
    logic signed [31:0] r_p [0:5];

    assign w_nx = i_s_tdata[15:0];
    assign w_ny = i_s_tdata[31:16];
    assign w_nz = i_s_tdata[47:32];
    assign w_vx = i_s_tdata[63:48];
    assign w_vy = i_s_tdata[79:64];
    assign w_vz = i_s_tdata[95:80];
    assign w_fx = i_s_tdata[111:96];
    assign w_fy = i_s_tdata[127:112];
    assign w_fz = i_s_tdata[143:128];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0] <= w_fx * w_vx;
            r_p[1] <= w_fy * w_vy;
            r_p[2] <= w_fz * w_vz;
            r_p[3] <= w_vx * w_nx;
            r_p[4] <= w_vy * w_ny;
            r_p[5] <= w_vz * w_nz;
        end
    end

    // ---------------- Stage 2: dot products m.v and v.n ----------------
    logic signed [33:0] r_mv, r_vn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mv <= 34'(r_p[0]) + 34'(r_p[1]) + 34'(r_p[2]);
            r_vn <= 34'(r_p[3]) + 34'(r_p[4]) + 34'(r_p[5]);
        end
    end

    // ---------------- Stage 3: sign test, |m.v| to 30 fraction bits ----------------
    logic [33:0] w_mag;
    logic        w_back;
    logic [29:0] r_c;
    t_tag        r_tag3;

    assign w_mag  = r_mv[33] ? 34'(-r_mv) : 34'(r_mv);
    assign w_back = (r_mv[33] && !r_vn[33]) || (!r_mv[33] && (r_mv != '0) && r_vn[33]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c         <= {w_mag[27:0], 2'b00};
            r_tag3.back <= w_back;
            r_tag3.sat  <= |w_mag[33:28];   // |m.v| >= 1: denominator not positive
        end
    end

    // ---------------- Stage 4: (m.v)^2 ----------------
    logic [59:0] w_csq;
    logic [29:0] r_c2;
    t_tag        r_tag4;

    assign w_csq = 60'(r_c) * 60'(r_c);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2   <= w_csq[59:30];
            r_tag4 <= r_tag3;
        end
    end

    // ---------------- Stage 5: denominator, ratio overflow check, divider load ----------------
    logic [30:0] w_d;
    t_div1       r_dv [0:DIV1_BITS];

    assign w_d = 31'(1 << 30) - {1'b0, r_c2};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv[0].den      <= w_d;
            r_dv[0].rem      <= {7'b0, r_c2[29:6]};
            r_dv[0].quo      <= '0;
            r_dv[0].low      <= r_c2[5:0];
            r_dv[0].tag.back <= r_tag4.back;
            // ratio >= 64 exactly when c2 >= 64 * d
            r_dv[0].tag.sat  <= r_tag4.sat || ({7'b0, r_c2} >= {w_d, 6'b0});
        end
    end

    // ---------------- Ratio divider: one quotient bit a stage ----------------
    for (genvar k = 1; k <= DIV1_BITS; k++) begin : g_div1
        logic        w_bit;
        logic [31:0] w_trial;
        logic        w_ge;

        if (DIV1_BITS - k >= 32) begin : g_hi
            assign w_bit = r_dv[k-1].low[DIV1_BITS-k-32];
        end else begin : g_lo
            assign w_bit = 1'b0;
        end

        assign w_trial = {r_dv[k-1].rem, w_bit};
        assign w_ge    = w_trial >= {1'b0, r_dv[k-1].den};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[k].den <= r_dv[k-1].den;
                r_dv[k].rem <= w_ge ? 31'(w_trial - {1'b0, r_dv[k-1].den}) : w_trial[30:0];
                r_dv[k].quo <= {r_dv[k-1].quo[36:0], w_ge};
                r_dv[k].low <= r_dv[k-1].low;
                r_dv[k].tag <= r_dv[k-1].tag;
            end
        end
    end

    // ---------------- Scale by exponent: two partial products ----------------
    logic [24:0] w_k;
    logic [43:0] r_pk_hi, r_pk_lo;
    t_tag        r_tag_m1;

    assign w_k = 25'(r_phong_exponent) + 25'd512;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pk_hi  <= 44'(w_k) * 44'(r_dv[DIV1_BITS].quo[37:19]);
            r_pk_lo  <= 44'(w_k) * 44'(r_dv[DIV1_BITS].quo[18:0]);
            r_tag_m1 <= r_dv[DIV1_BITS].tag;
        end
    end

    // ---------------- Combine into a^2, check a >= 1.6, root load ----------------
    logic [63:0] w_a2;
    t_sqrt       r_sq [0:SQRT_BITS];

    assign w_a2 = (({20'b0, r_pk_hi} << 19) + {20'b0, r_pk_lo}) >> 9;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq[0].x        <= w_a2[33:0];
            r_sq[0].rem      <= '0;
            r_sq[0].root     <= '0;
            r_sq[0].tag.back <= r_tag_m1.back;
            r_sq[0].tag.sat  <= r_tag_m1.sat || (w_a2 >= A2_SAT);
        end
    end

    // ---------------- Square root: one result bit a stage ----------------
    for (genvar k = 1; k <= SQRT_BITS; k++) begin : g_sqrt
        localparam int Pos = 2 * (SQRT_BITS - k);
        logic [20:0] w_cur;
        logic [20:0] w_try;
        logic        w_ge;

        assign w_cur = {r_sq[k-1].rem, r_sq[k-1].x[Pos+1:Pos]};
        assign w_try = {2'b0, r_sq[k-1].root, 2'b01};
        assign w_ge  = w_cur >= w_try;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[k].x    <= r_sq[k-1].x;
                r_sq[k].rem  <= w_ge ? 19'(w_cur - w_try) : w_cur[18:0];
                r_sq[k].root <= {r_sq[k-1].root[15:0], w_ge};
                r_sq[k].tag  <= r_sq[k-1].tag;
            end
        end
    end

    // ---------------- a and a^2 ----------------
    logic [33:0] w_asq;
    logic [16:0] r_a;
    logic [17:0] r_aa;
    t_tag        r_tag_q1;

    assign w_asq = 34'(r_sq[SQRT_BITS].root) * 34'(r_sq[SQRT_BITS].root);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a      <= r_sq[SQRT_BITS].root;
            r_aa     <= w_asq[33:16];
            r_tag_q1 <= r_sq[SQRT_BITS].tag;
        end
    end

    // ---------------- Coefficient products ----------------
    logic [35:0] r_pa1, r_pa2, r_pb1, r_pb2;
    t_tag        r_tag_q2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa1    <= 36'(K_A1) * 36'(r_a);
            r_pa2    <= 36'(K_A2) * 36'(r_aa);
            r_pb1    <= 36'(K_B1) * 36'(r_a);
            r_pb2    <= 36'(K_B2) * 36'(r_aa);
            r_tag_q2 <= r_tag_q1;
        end
    end

    // ---------------- Numerator, denominator, divider load ----------------
    logic [36:0] w_num_s, w_den_s;
    logic [20:0] w_num, w_den;
    t_div2       r_d2 [0:DIV2_BITS];

    assign w_num_s = 37'(r_pa1) + 37'(r_pa2);
    assign w_den_s = 37'(64'd1 << 32) + 37'(r_pb1) + 37'(r_pb2);
    assign w_num   = w_num_s[36:16];
    assign w_den   = w_den_s[36:16];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2[0].den      <= w_den;
            r_d2[0].rem      <= {1'b0, w_num[20:1]};
            r_d2[0].quo      <= '0;
            r_d2[0].low      <= w_num[0];
            r_d2[0].tag.back <= r_tag_q2.back;
            // quotient would need a 17th bit: clamp anyway
            r_d2[0].tag.sat  <= r_tag_q2.sat || ({1'b0, w_num} >= {w_den, 1'b0});
        end
    end

    // ---------------- Rational quotient: one bit a stage ----------------
    for (genvar k = 1; k <= DIV2_BITS; k++) begin : g_div2
        logic        w_bit;
        logic [21:0] w_trial;
        logic        w_ge;

        if (k == 1) begin : g_first
            assign w_bit = r_d2[k-1].low;
        end else begin : g_rest
            assign w_bit = 1'b0;
        end

        assign w_trial = {r_d2[k-1].rem, w_bit};
        assign w_ge    = w_trial >= {1'b0, r_d2[k-1].den};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d2[k].den <= r_d2[k-1].den;
                r_d2[k].rem <= w_ge ? 21'(w_trial - {1'b0, r_d2[k-1].den}) : w_trial[20:0];
                r_d2[k].quo <= {r_d2[k-1].quo[14:0], w_ge};
                r_d2[k].low <= r_d2[k-1].low;
                r_d2[k].tag <= r_d2[k-1].tag;
            end
        end
    end

    // ---------------- Output register: select and clamp ----------------
    logic [15:0] n_out_tdata;
    logic [15:0] r_out_tdata;
    logic        r_out_tuser;
    t_tag        w_tag_f;
    logic [15:0] w_quo_f;

    assign w_tag_f = r_d2[DIV2_BITS].tag;
    assign w_quo_f = r_d2[DIV2_BITS].quo;

    always_comb begin
        priority if (w_tag_f.back) begin
            n_out_tdata = '0;
        end else if (w_tag_f.sat || (w_quo_f > SHADOW_ONE)) begin
            n_out_tdata = SHADOW_ONE;
        end else begin
            n_out_tdata = w_quo_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= w_tag_f.back;
        end
    end

    assign o_m_tvalid = r_vld[LATENCY-1];
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

    // ---------------- Assertions ----------------
    a_back_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("backfacing result with nonzero shadowing");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata <= SHADOW_ONE))
        else $error("shadowing above 1.0");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en) |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

endmodule
